// File: rtl/core/hqm_pkg.sv
package hqm_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam int NODE_W     = 4;
  localparam int MASK_W     = 16;
  localparam int TIMEOUT_W  = 16;
  localparam int COUNT_W    = 5;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W     = 32;

  localparam logic [TIMEOUT_W-1:0] LIVE_TIMEOUT_RST    = 16'd5000;
  localparam logic [TIMEOUT_W-1:0] SUSPECT_TIMEOUT_RST = 16'd4000;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEARTBEAT = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_LOAD_VIEW = 3'd2,
    CMD_FORGET    = 3'd3,
    CMD_EVALUATE  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT      = 3'd0,
    REG_SELF_NODE       = 3'd1,
    REG_LIVE_TIMEOUT    = 3'd2,
    REG_SUSPECT_TIMEOUT = 3'd3,
    REG_TWO_NODE_ARB    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

// File: rtl/core/hqm_stamp_ram.sv
module hqm_stamp_ram import hqm_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic              wr_clear,
  input  logic [AW-1:0]     wr_addr,
  input  logic [TICK_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [TICK_W-1:0] rd_data
);

  logic [TICK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [TICK_W-1:0] rdata_r;
  logic              rvalid_r;

  always_ff @(posedge clk) begin
    if (wr_en && !wr_clear) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rvalid_r <= valid_r[rd_addr];
    end
  end

  // An entry never stamped, or forgotten, reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= !wr_clear;
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule

// File: rtl/core/hqm_scan.sv
module hqm_scan import hqm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                 clk,
  input  scan_ctl_t            ctl,
  input  logic [TICK_W-1:0]    stamp,
  input  logic [TICK_W-1:0]    now,
  input  logic [NODE_W-1:0]    self_node,
  input  logic [TIMEOUT_W-1:0] live_timeout,
  input  logic [TIMEOUT_W-1:0] suspect_timeout,
  input  logic [MAX_NODES-1:0] view,
  output logic [MAX_NODES-1:0] live,
  output logic [MAX_NODES-1:0] suspect,
  output logic [MAX_NODES-1:0] used,
  output logic [CW-1:0]        live_count,
  output logic [COUNT_W-1:0]   view_count,
  output logic [NODE_W-1:0]    lead
);

  logic [MAX_NODES-1:0] bit_r;
  logic [CW-1:0]        idx_r;
  logic [MAX_NODES-1:0] live_r;
  logic [MAX_NODES-1:0] suspect_r;
  logic [MAX_NODES-1:0] used_r;
  logic [CW-1:0]        live_count_r;
  logic [COUNT_W-1:0]   view_count_r;
  logic [NODE_W-1:0]    lead_r;
  logic                 found_r;

  logic [TICK_W-1:0] age;
  logic              is_self;
  logic              live_hit;
  logic              dead;
  logic              view_hit;

  // The single age unit: one subtract and two compares per visited node.
  always_comb begin
    age      = now - stamp;
    is_self  = (32'(idx_r) == 32'(self_node));
    live_hit = is_self || (age < TICK_W'(live_timeout));
    dead     = (age > TICK_W'(suspect_timeout));
    view_hit = |(bit_r & view);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      bit_r        <= MAX_NODES'(1);
      idx_r        <= '0;
      live_r       <= '0;
      suspect_r    <= '0;
      used_r       <= '0;
      live_count_r <= '0;
      view_count_r <= '0;
      lead_r       <= '0;
      found_r      <= 1'b0;
    end else if (ctl.step) begin
      bit_r  <= bit_r << 1;
      idx_r  <= idx_r + CW'(1);
      used_r <= used_r | bit_r;
      if (live_hit) begin
        live_r       <= live_r | bit_r;
        live_count_r <= live_count_r + CW'(1);
      end
      if (!is_self && dead) begin
        suspect_r <= suspect_r | bit_r;
      end
      if (view_hit) begin
        view_count_r <= view_count_r + COUNT_W'(1);
        if (!found_r && !dead) begin
          found_r <= 1'b1;
          lead_r  <= NODE_W'(idx_r);
        end
      end
    end
  end

  assign live       = live_r;
  assign suspect    = suspect_r;
  assign used       = used_r;
  assign live_count = live_count_r;
  assign view_count = view_count_r;
  assign lead       = lead_r;

endmodule

// File: rtl/core/heartbeat_quorum_monitor_top.sv
// Heartbeat, tick, load view and forget requests complete in the cycle they are accepted.
// Evaluate visits one node per cycle in the scan state, up to n, the clamped node count;
// the finish state then registers the result strobe; busy is high in both states. The
// stamp memory read port and the shared age unit set the rate. Results cannot be stalled.
// Synchronous active-low reset does not clear stamp data, scan state or result fields.
module heartbeat_quorum_monitor_top import hqm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [NODE_W-1:0]     in_node_index,
  input  logic [MASK_W-1:0]     in_view_mask,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [MASK_W-1:0]     out_live_mask,
  output logic [MASK_W-1:0]     out_suspect_mask,
  output logic [NODE_W-1:0]     out_leader_index,
  output logic                  out_is_leader,
  output logic                  out_has_quorum,
  output logic [COUNT_W-1:0]    out_view_count,
  output logic                  out_send_view,
  output logic                  out_deliver_view
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  logic [COUNT_W-1:0]   node_count_r;
  logic [NODE_W-1:0]    self_node_r;
  logic [TIMEOUT_W-1:0] live_timeout_r;
  logic [TIMEOUT_W-1:0] suspect_timeout_r;
  logic                 arbiter_r;

  logic [TICK_W-1:0]    now_r;
  logic [MASK_W-1:0]    global_view_r;
  logic [MAX_NODES-1:0] local_view_r;
  logic                 send_pending_r;
  logic                 deliver_pending_r;

  state_t         state_r;
  state_t         state_nxt;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  cnt_nxt;
  logic           step_r;

  logic           accept;
  cmd_t           cmd;
  logic [CW-1:0]  n_used;
  logic           idx_in_range;
  logic           wr_en;
  logic           wr_clear;
  logic           rd_en;
  logic [TICK_W-1:0] stamp;
  scan_ctl_t      scan_ctl;

  logic [MAX_NODES-1:0] view_ext;
  logic [MAX_NODES-1:0] live;
  logic [MAX_NODES-1:0] suspect;
  logic [MAX_NODES-1:0] used;
  logic [CW-1:0]        live_count;
  logic [COUNT_W-1:0]   view_count;
  logic [NODE_W-1:0]    lead;

  logic fin_quorum;
  logic fin_is_leader;
  logic fin_send_pending;
  logic fin_send;
  logic fin_local_change;
  logic fin_deliver;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cmd       = cmd_t'(in_command);

  assign n_used = (32'(node_count_r) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_r);
  assign idx_in_range = (32'(in_node_index) < 32'(n_used));
  assign view_ext = MAX_NODES'(global_view_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r      <= '0;
      self_node_r       <= '0;
      live_timeout_r    <= LIVE_TIMEOUT_RST;
      suspect_timeout_r <= SUSPECT_TIMEOUT_RST;
      arbiter_r         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_COUNT:      node_count_r      <= cfg_data[COUNT_W-1:0];
        REG_SELF_NODE:       self_node_r       <= cfg_data[NODE_W-1:0];
        REG_LIVE_TIMEOUT:    live_timeout_r    <= cfg_data[TIMEOUT_W-1:0];
        REG_SUSPECT_TIMEOUT: suspect_timeout_r <= cfg_data[TIMEOUT_W-1:0];
        REG_TWO_NODE_ARB:    arbiter_r         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_clear = 1'b0;
    if (accept && idx_in_range) begin
      if (cmd == CMD_HEARTBEAT) begin
        wr_en = 1'b1;
      end else if (cmd == CMD_FORGET) begin
        wr_en    = 1'b1;
        wr_clear = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_EVALUATE) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_r == n_used) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en          = (state_r == ST_SCAN) && (cnt_r < n_used);
    scan_ctl.clear = accept && (cmd == CMD_EVALUATE);
    scan_ctl.step  = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= rd_en;
    end
  end

  hqm_stamp_ram #(
    .DEPTH (MAX_NODES)
  ) u_stamp_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_clear (wr_clear),
    .wr_addr  (AW'(in_node_index)),
    .wr_data  (now_r),
    .rd_en    (rd_en),
    .rd_addr  (cnt_r[AW-1:0]),
    .rd_data  (stamp)
  );

  hqm_scan #(
    .MAX_NODES (MAX_NODES)
  ) u_scan (
    .clk             (clk),
    .ctl             (scan_ctl),
    .stamp           (stamp),
    .now             (now_r),
    .self_node       (self_node_r),
    .live_timeout    (live_timeout_r),
    .suspect_timeout (suspect_timeout_r),
    .view            (view_ext),
    .live            (live),
    .suspect         (suspect),
    .used            (used),
    .live_count      (live_count),
    .view_count      (view_count),
    .lead            (lead)
  );

  always_comb begin
    fin_quorum = (n_used != '0) &&
                 ((live_count > (n_used >> 1)) || (arbiter_r && (32'(n_used) == 2)));
    fin_is_leader    = (lead == self_node_r);
    fin_send_pending = send_pending_r || ((view_ext & used) != live);
    fin_send         = fin_send_pending && fin_is_leader && fin_quorum;
    fin_local_change = ((local_view_r & used) != live);
    fin_deliver      = deliver_pending_r || fin_local_change;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r             <= '0;
      global_view_r     <= '0;
      local_view_r      <= '0;
      send_pending_r    <= 1'b1;
      deliver_pending_r <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_FINISH);
      if (accept && cmd == CMD_TICK) begin
        now_r <= now_r + TICK_W'(1);
      end
      if (accept && cmd == CMD_LOAD_VIEW) begin
        global_view_r <= in_view_mask;
      end
      if (state_r == ST_FINISH) begin
        send_pending_r    <= fin_send_pending && !fin_send;
        deliver_pending_r <= 1'b0;
        local_view_r      <= (local_view_r & ~used) | live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      out_live_mask    <= MASK_W'(live);
      out_suspect_mask <= MASK_W'(suspect);
      out_leader_index <= lead;
      out_is_leader    <= fin_is_leader;
      out_has_quorum   <= fin_quorum;
      out_view_count   <= view_count;
      out_send_view    <= fin_send;
      out_deliver_view <= fin_deliver;
    end
  end

endmodule

// File: sim/heartbeat_quorum_monitor_top_tb.sv
module heartbeat_quorum_monitor_top_tb;
  import hqm_pkg::*;

  localparam int MAX_NODES      = MAX_NODES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_LEG  = 160;
  localparam int LEG_COUNT      = 5;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [MASK_W-1:0]  live_mask;
    logic [MASK_W-1:0]  suspect_mask;
    logic [NODE_W-1:0]  leader_index;
    logic               is_leader;
    logic               has_quorum;
    logic [COUNT_W-1:0] view_count;
    logic               send_view;
    logic               deliver_view;
  } view_report_t;

  typedef enum logic {
    ROW_REQ,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CMD_W-1:0]       cmd;
    logic [NODE_W-1:0]      node;
    logic [MASK_W-1:0]      view;
    cfg_reg_t               reg_sel;
    logic [CFG_DATA_W-1:0]  reg_val;
    bit                     typed;
    view_report_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      in_command;
  logic [NODE_W-1:0]     in_node_index;
  logic [MASK_W-1:0]     in_view_mask;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic [MASK_W-1:0]     out_live_mask;
  logic [MASK_W-1:0]     out_suspect_mask;
  logic [NODE_W-1:0]     out_leader_index;
  logic                  out_is_leader;
  logic                  out_has_quorum;
  logic [COUNT_W-1:0]    out_view_count;
  logic                  out_send_view;
  logic                  out_deliver_view;

  heartbeat_quorum_monitor_top #(
    .MAX_NODES(MAX_NODES)
  ) dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the detector: configuration, tick clock, stamps and views.
  logic [COUNT_W-1:0]   cfg_count;
  logic [NODE_W-1:0]    cfg_self;
  logic [TIMEOUT_W-1:0] cfg_live_to;
  logic [TIMEOUT_W-1:0] cfg_suspect_to;
  logic                 cfg_arbiter;
  logic [TICK_W-1:0]    now_tick;
  logic [TICK_W-1:0]    heard_at [MAX_NODES];
  logic [MASK_W-1:0]    agreed_view;
  logic [MASK_W-1:0]    local_view;
  logic                 send_owed;
  logic                 deliver_owed;

  view_report_t pending_reports[$];
  stim_row_t    directed_rows[$];
  int           fault_count = 0;
  int           quiet_cycles = 0;

  task automatic reset_shadow();
    cfg_count      = '0;
    cfg_self       = '0;
    cfg_live_to    = LIVE_TIMEOUT_RST;
    cfg_suspect_to = SUSPECT_TIMEOUT_RST;
    cfg_arbiter    = 1'b0;
    now_tick       = '0;
    for (int i = 0; i < MAX_NODES; i++) heard_at[i] = '0;
    agreed_view    = '0;
    local_view     = '0;
    send_owed      = 1'b1;
    deliver_owed   = 1'b1;
  endtask

  task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                               input logic [MASK_W-1:0] view, output bit made,
                               output view_report_t rep);
    int unsigned       n;
    int unsigned       live_cnt;
    logic [MASK_W-1:0] used;
    logic [TICK_W-1:0] age;
    bit                found;
    bit                dead;
    made = 1'b0;
    rep = '0;
    n = (cfg_count > MAX_NODES) ? MAX_NODES : cfg_count;
    unique case (cmd)
      CMD_HEARTBEAT: if (node < n) heard_at[node] = now_tick;
      CMD_TICK:      now_tick = now_tick + 1;
      CMD_LOAD_VIEW: agreed_view = view;
      CMD_FORGET:    if (node < n) heard_at[node] = '0;
      CMD_EVALUATE: begin
        used = '0;
        live_cnt = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          age = now_tick - heard_at[i];
          dead = age > TICK_W'(cfg_suspect_to);
          used[i] = 1'b1;
          if (i == cfg_self || age < TICK_W'(cfg_live_to)) begin
            rep.live_mask[i] = 1'b1;
            live_cnt++;
          end
          if (i != cfg_self && dead) rep.suspect_mask[i] = 1'b1;
          if (agreed_view[i]) begin
            rep.view_count++;
            if (!found && !dead) begin
              found = 1'b1;
              rep.leader_index = NODE_W'(i);
            end
          end
        end
        if ((agreed_view & used) != rep.live_mask) send_owed = 1'b1;
        rep.has_quorum = (n > 0) && (live_cnt > n / 2 || (cfg_arbiter && n == 2));
        rep.is_leader = (rep.leader_index == cfg_self);
        rep.send_view = send_owed && rep.is_leader && rep.has_quorum;
        if (rep.send_view) send_owed = 1'b0;
        if ((local_view & used) != rep.live_mask) begin
          local_view = (local_view & ~used) | rep.live_mask;
          deliver_owed = 1'b1;
        end
        rep.deliver_view = deliver_owed;
        deliver_owed = 1'b0;
        made = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    view_report_t got;
    view_report_t want;
    if (rst_n && out_valid) begin
      got = {out_live_mask, out_suspect_mask, out_leader_index, out_is_leader,
             out_has_quorum, out_view_count, out_send_view, out_deliver_view};
      if (pending_reports.size() == 0) begin
        fault_count++;
        $display("%0t: report with none expected: expected nothing, actual 0x%0h",
                 $time, got);
      end else begin
        want = pending_reports.pop_front();
        check_field("live_mask", want.live_mask, got.live_mask);
        check_field("suspect_mask", want.suspect_mask, got.suspect_mask);
        check_field("leader_index", want.leader_index, got.leader_index);
        check_field("is_leader", want.is_leader, got.is_leader);
        check_field("has_quorum", want.has_quorum, got.has_quorum);
        check_field("view_count", want.view_count, got.view_count);
        check_field("send_view", want.send_view, got.send_view);
        check_field("deliver_view", want.deliver_view, got.deliver_view);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                              input logic [MASK_W-1:0] view, input bit typed,
                              input view_report_t want);
    bit           made;
    view_report_t rep;
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_node_index = node;
    in_view_mask = view;
    do @(posedge clk); while (busy);
    apply_request(cmd, node, view, made, rep);
    if (made) pending_reports.push_back(typed ? want : rep);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (MAX_NODES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    unique case (sel)
      REG_NODE_COUNT:      cfg_count = val[COUNT_W-1:0];
      REG_SELF_NODE:       cfg_self = val[NODE_W-1:0];
      REG_LIVE_TIMEOUT:    cfg_live_to = val[TIMEOUT_W-1:0];
      REG_SUSPECT_TIMEOUT: cfg_suspect_to = val[TIMEOUT_W-1:0];
      REG_TWO_NODE_ARB:    cfg_arbiter = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    if ($urandom_range(0, 9) == 0) return TIMEOUT_W'($urandom_range(0, 65535));
    return TIMEOUT_W'($urandom_range(0, 24));
  endfunction

  function automatic stim_row_t req_row(input logic [CMD_W-1:0] cmd,
                                        input logic [NODE_W-1:0] node,
                                        input logic [MASK_W-1:0] view);
    stim_row_t r;
    r = '{kind: ROW_REQ, cmd: cmd, node: node, view: view, reg_sel: REG_NODE_COUNT,
          reg_val: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t reg_row(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = req_row(CMD_TICK, '0, '0);
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input view_report_t want);
    stim_row_t r;
    r = req_row(CMD_EVALUATE, '0, '0);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  initial begin
    int unsigned       idle_pct [LEG_COUNT];
    int unsigned       pick;
    logic [CMD_W-1:0]  cmd;
    stim_row_t         row;

    idle_pct = '{0, 57, 6, 0, 57};
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_HEARTBEAT;
    in_node_index = '0;
    in_view_mask = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    reset_shadow();

    // With no members the scan is empty; the first evaluate still owes a delivery.
    directed_rows.push_back(typed_row('{16'h0000, 16'h0000, 4'd0, 1'b1, 1'b0, 5'd0, 1'b0,
                                        1'b1}));
    directed_rows.push_back(req_row(CMD_SPARE_LO, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_SPARE_MID, 4'd15, 16'hFFFF));
    directed_rows.push_back(req_row(CMD_SPARE_HI, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_HEARTBEAT, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_FORGET, 4'd15, 16'h0000));
    directed_rows.push_back(typed_row('{16'h0000, 16'h0000, 4'd0, 1'b1, 1'b0, 5'd0, 1'b0,
                                        1'b0}));
    directed_rows.push_back(reg_row(REG_NODE_COUNT, 16'd16));
    directed_rows.push_back(req_row(CMD_LOAD_VIEW, 4'd0, 16'hFFFF));
    directed_rows.push_back(req_row(CMD_HEARTBEAT, 4'd15, 16'h0000));
    directed_rows.push_back(typed_row('{16'hFFFF, 16'h0000, 4'd0, 1'b1, 1'b1, 5'd16, 1'b1,
                                        1'b1}));
    directed_rows.push_back(reg_row(REG_SELF_NODE, 16'd15));
    directed_rows.push_back(reg_row(REG_LIVE_TIMEOUT, 16'd0));
    directed_rows.push_back(reg_row(REG_SUSPECT_TIMEOUT, 16'd0));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_TICK, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd15, 16'hFFFF));
    directed_rows.push_back(req_row(CMD_LOAD_VIEW, 4'd0, 16'h8001));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_HEARTBEAT, 4'd3, 16'h0000));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(req_row(CMD_FORGET, 4'd3, 16'h0000));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(reg_row(REG_NODE_COUNT, 16'd31));
    directed_rows.push_back(reg_row(REG_LIVE_TIMEOUT, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_SUSPECT_TIMEOUT, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_TWO_NODE_ARB, 16'd1));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(reg_row(REG_NODE_COUNT, 16'd2));
    directed_rows.push_back(req_row(CMD_HEARTBEAT, 4'd9, 16'h0000));
    directed_rows.push_back(req_row(CMD_FORGET, 4'd14, 16'h0000));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));
    directed_rows.push_back(reg_row(REG_TWO_NODE_ARB, 16'd0));
    directed_rows.push_back(req_row(CMD_EVALUATE, 4'd0, 16'h0000));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        send_request(row.cmd, row.node, row.view, row.typed, row.want);
      end
    end

    for (int leg = 0; leg < LEG_COUNT; leg++) begin
      drain();
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_NODE_COUNT, CFG_DATA_W'($urandom_range(0, 31)));
      end else begin
        write_reg(REG_NODE_COUNT, CFG_DATA_W'($urandom_range(2, 16)));
      end
      write_reg(REG_SELF_NODE, CFG_DATA_W'($urandom_range(0, 15)));
      write_reg(REG_LIVE_TIMEOUT, pick_timeout());
      write_reg(REG_SUSPECT_TIMEOUT, pick_timeout());
      write_reg(REG_TWO_NODE_ARB, CFG_DATA_W'($urandom_range(0, 1)));
      for (int k = 0; k < ITEMS_PER_LEG; k++) begin
        if ($urandom_range(0, 99) < idle_pct[leg]) begin
          @(negedge clk);
          start = 1'b0;
          repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 28) cmd = CMD_HEARTBEAT;
        else if (pick < 56) cmd = CMD_TICK;
        else if (pick < 76) cmd = CMD_EVALUATE;
        else if (pick < 86) cmd = CMD_LOAD_VIEW;
        else if (pick < 94) cmd = CMD_FORGET;
        else cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_request(cmd, NODE_W'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 65535)),
                     1'b0, '0);
      end
    end

    drain();
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
